// File: rtl/idtp_pkg.sv
package idtp_pkg;

    localparam int CHAR_W   = 8;
    localparam int POS_W    = 5;
    localparam int FMT_W    = 2;
    localparam int YACC_W   = 14;
    localparam int FACC_W   = 7;
    localparam int KIND_W   = 4;

    localparam logic [FMT_W-1:0] FMT_DATE_TIME = 2'd0;
    localparam logic [FMT_W-1:0] FMT_DATE      = 2'd1;
    localparam logic [FMT_W-1:0] FMT_TIME      = 2'd2;

    localparam logic [KIND_W-1:0] K_YEAR  = 4'd0;
    localparam logic [KIND_W-1:0] K_MON   = 4'd1;
    localparam logic [KIND_W-1:0] K_DAY   = 4'd2;
    localparam logic [KIND_W-1:0] K_HOUR  = 4'd3;
    localparam logic [KIND_W-1:0] K_MIN   = 4'd4;
    localparam logic [KIND_W-1:0] K_SEC   = 4'd5;
    localparam logic [KIND_W-1:0] K_DASH  = 4'd6;
    localparam logic [KIND_W-1:0] K_COLON = 4'd7;
    localparam logic [KIND_W-1:0] K_SEP   = 4'd8;
    localparam logic [KIND_W-1:0] K_NONE  = 4'd9;

    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [POS_W-1:0] POS_SAT = 5'd20;

    localparam logic [POS_W-1:0] LEN_DT_SHORT = 5'd16;
    localparam logic [POS_W-1:0] LEN_DT_LONG  = 5'd19;
    localparam logic [POS_W-1:0] LEN_DATE     = 5'd10;
    localparam logic [POS_W-1:0] LEN_T_SHORT  = 5'd5;
    localparam logic [POS_W-1:0] LEN_T_LONG   = 5'd8;

    localparam logic [YACC_W-1:0] YEAR_MIN = 14'd2000;
    localparam logic [YACC_W-1:0] YEAR_MAX = 14'd2099;
    localparam logic [FACC_W-1:0] HOUR_MAX = 7'd23;
    localparam logic [FACC_W-1:0] MIN_MAX  = 7'd59;

    // accumulated digits of one string
    typedef struct packed {
        logic [YACC_W-1:0] year;
        logic [FACC_W-1:0] month;
        logic [FACC_W-1:0] day;
        logic [FACC_W-1:0] hour;
        logic [FACC_W-1:0] minute;
        logic [FACC_W-1:0] second;
    } idtp_acc_t;

    // finished string handed to the checker
    typedef struct packed {
        idtp_acc_t         acc;
        logic              err;
        logic [POS_W-1:0]  len;
        logic [FMT_W-1:0]  fmt;
    } idtp_snap_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } idtp_res_t;

    function automatic logic [KIND_W-1:0] char_kind(input logic [FMT_W-1:0] fmt,
                                                    input logic [POS_W-1:0] pos);
        logic [KIND_W-1:0] k;
        k = K_NONE;
        case (fmt)
            FMT_DATE_TIME, FMT_DATE:
            begin
                case (pos)
                    5'd0, 5'd1, 5'd2, 5'd3: k = K_YEAR;
                    5'd4, 5'd7:             k = K_DASH;
                    5'd5, 5'd6:             k = K_MON;
                    5'd8, 5'd9:             k = K_DAY;
                    default:                k = K_NONE;
                endcase
                if (fmt == FMT_DATE_TIME)
                begin
                    case (pos)
                        5'd10:        k = K_SEP;
                        5'd11, 5'd12: k = K_HOUR;
                        5'd13, 5'd16: k = K_COLON;
                        5'd14, 5'd15: k = K_MIN;
                        5'd17, 5'd18: k = K_SEC;
                        default:      k = k;
                    endcase
                end
            end
            FMT_TIME:
            begin
                case (pos)
                    5'd0, 5'd1: k = K_HOUR;
                    5'd2, 5'd5: k = K_COLON;
                    5'd3, 5'd4: k = K_MIN;
                    5'd6, 5'd7: k = K_SEC;
                    default:    k = K_NONE;
                endcase
            end
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] month_last_day(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:                    d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/idtp_check.sv
module idtp_check (
    input  idtp_pkg::idtp_snap_t snap,
    output idtp_pkg::idtp_res_t  res
);
    import idtp_pkg::*;

    logic date_ok;
    logic time_ok;
    logic len_ok;
    logic leap;
    logic ok;
    logic use_date;
    logic use_time;

    // inside 2000..2099 the century rule only touches 2000, which is a leap year
    assign leap = (snap.acc.year[1:0] == 2'b00);

    assign date_ok = (snap.acc.year >= YEAR_MIN) && (snap.acc.year <= YEAR_MAX)
                  && (snap.acc.month >= 7'd1) && (snap.acc.month <= 7'd12)
                  && (snap.acc.day >= 7'd1)
                  && (snap.acc.day <= {2'b00, month_last_day(snap.acc.month[3:0], leap)});

    assign time_ok = (snap.acc.hour <= HOUR_MAX) && (snap.acc.minute <= MIN_MAX)
                  && (snap.acc.second <= MIN_MAX);

    always_comb
    begin
        len_ok   = 1'b0;
        use_date = 1'b0;
        use_time = 1'b0;
        case (snap.fmt)
            FMT_DATE_TIME:
            begin
                len_ok   = (snap.len == LEN_DT_SHORT) || (snap.len == LEN_DT_LONG);
                use_date = 1'b1;
                use_time = 1'b1;
            end
            FMT_DATE:
            begin
                len_ok   = (snap.len == LEN_DATE);
                use_date = 1'b1;
            end
            FMT_TIME:
            begin
                len_ok   = (snap.len == LEN_T_SHORT) || (snap.len == LEN_T_LONG);
                use_time = 1'b1;
            end
            default:
            begin
                len_ok = 1'b0;
            end
        endcase
    end

    assign ok = !snap.err && len_ok && (date_ok || !use_date) && (time_ok || !use_time);

    always_comb
    begin
        res        = '0;
        res.ok     = ok;
        if (ok && use_date)
        begin
            res.year  = snap.acc.year[11:0];
            res.month = snap.acc.month[3:0];
            res.day   = snap.acc.day[4:0];
        end
        if (ok && use_time)
        begin
            res.hour   = snap.acc.hour[4:0];
            res.minute = snap.acc.minute[5:0];
            res.second = snap.acc.second[5:0];
        end
    end

endmodule

// File: rtl/iso_date_time_text_parser.sv
// Date/time text parser.
// Input channel (in_valid/in_ready): one ASCII character per request, with
// last_char high on the final character of a string. Characters are checked
// against the layout chosen by text_format (0 date and time, 1 date only,
// 2 time only) and their digits are accumulated as they arrive.
// Output channel (out_valid/out_ready): one request per string, issued for the
// character flagged last: valid_res plus year..second, all fields zero when
// the string is not legal.
// A result passes the snapshot and then the output register. One character is
// taken per cycle while in_ready is high; the per-character step is one position
// decode and one multiply-by-ten accumulate, the final check one range compare
// stage between the snapshot and output registers. When the receiver stalls, one
// finished string waits in the snapshot stage and one in the output register;
// after that in_ready drops until out_ready returns. Reset clears string state,
// both valid flags and sets text_format to 0. The user writes text_format over
// the APB port only while no string is in flight; the block does not enforce it.
module iso_date_time_text_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_char,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);
    import idtp_pkg::*;

    logic [FMT_W-1:0] fmt_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             err_reg;
    logic             err_next;
    idtp_acc_t        acc_reg;
    idtp_acc_t        acc_next;

    idtp_snap_t       snap_reg;
    logic             snap_valid_reg;
    idtp_res_t        res_next;
    idtp_res_t        res_reg;
    logic             out_valid_reg;

    logic              accept;
    logic              advance;
    logic [KIND_W-1:0] kind;
    logic              is_digit;
    logic [3:0]        digit;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {{(32-FMT_W){1'b0}}, fmt_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_DATE_TIME;
        else if (cfg_write)
            fmt_reg <= pwdata[FMT_W-1:0];
    end

    assign advance  = snap_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !snap_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign kind     = char_kind(fmt_reg, pos_reg);
    assign is_digit = (text_char >= CH_ZERO) && (text_char <= CH_NINE);
    assign digit    = is_digit ? text_char[3:0] : 4'd0;

    always_comb
    begin
        acc_next = acc_reg;
        err_next = err_reg;
        case (kind)
            K_YEAR, K_MON, K_DAY, K_HOUR, K_MIN, K_SEC:
            begin
                if (!is_digit)
                    err_next = 1'b1;
                else
                begin
                    case (kind)
                        K_YEAR:  acc_next.year   = (acc_reg.year << 3) + (acc_reg.year << 1)
                                                   + {{(YACC_W-4){1'b0}}, digit};
                        K_MON:   acc_next.month  = (acc_reg.month << 3) + (acc_reg.month << 1)
                                                   + {{(FACC_W-4){1'b0}}, digit};
                        K_DAY:   acc_next.day    = (acc_reg.day << 3) + (acc_reg.day << 1)
                                                   + {{(FACC_W-4){1'b0}}, digit};
                        K_HOUR:  acc_next.hour   = (acc_reg.hour << 3) + (acc_reg.hour << 1)
                                                   + {{(FACC_W-4){1'b0}}, digit};
                        K_MIN:   acc_next.minute = (acc_reg.minute << 3)
                                                   + (acc_reg.minute << 1)
                                                   + {{(FACC_W-4){1'b0}}, digit};
                        default: acc_next.second = (acc_reg.second << 3)
                                                   + (acc_reg.second << 1)
                                                   + {{(FACC_W-4){1'b0}}, digit};
                    endcase
                end
            end
            K_DASH:  if (text_char != CH_DASH) err_next = 1'b1;
            K_COLON: if (text_char != CH_COLON) err_next = 1'b1;
            K_SEP:   if ((text_char != CH_SPACE) && (text_char != CH_T)) err_next = 1'b1;
            default: err_next = 1'b1;
        endcase
    end

    // position saturates so an overlong string can never match a legal length
    assign pos_next = (pos_reg < POS_SAT) ? pos_reg + 5'd1 : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            err_reg <= 1'b0;
            acc_reg <= '0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                pos_reg <= '0;
                err_reg <= 1'b0;
                acc_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                err_reg <= err_next;
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (accept && last_char)
            snap_valid_reg <= 1'b1;
        else if (advance)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_char)
        begin
            snap_reg.acc <= acc_next;
            snap_reg.err <= err_next;
            snap_reg.len <= pos_reg + 5'd1;
            snap_reg.fmt <= fmt_reg;
        end
    end

    idtp_check u_check (
        .snap (snap_reg),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign valid_res = res_reg.ok;
    assign year      = res_reg.year;
    assign month     = res_reg.month;
    assign day       = res_reg.day;
    assign hour      = res_reg.hour;
    assign minute    = res_reg.minute;
    assign second    = res_reg.second;

endmodule

// File: rtl/idtp_assert.sv
module idtp_assert (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_char,
    input logic        out_valid,
    input logic        out_ready,
    input logic        valid_res,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
);

    // a stalled result keeps out_valid, valid_res, year and second
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(year)
                                    && $stable(second))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> year == 12'd0 && month == 4'd0 && day == 5'd0
                                    && hour == 5'd0 && minute == 6'd0 && second == 6'd0)
        else $error("fields not cleared on invalid string");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("time field out of range on valid result");

    // a fresh result is preceded by an accepted last character of a string
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last_char, 2))
        else $error("result without a finished string");

endmodule

bind iso_date_time_text_parser idtp_assert u_idtp_assert (.*);
